[rtl/time_span_moving_average_macros.svh]
`ifndef TIME_SPAN_MOVING_AVERAGE_MACROS_SVH
`define TIME_SPAN_MOVING_AVERAGE_MACROS_SVH

// Check that a condition is true at every edge outside reset.
`define TSMA_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another one at the same edge.
`define TSMA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one at the next edge.
`define TSMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tsma_pkg.sv]
package tsma_pkg;

  localparam int RING_DEPTH  = 256;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int COUNT_W     = $clog2(RING_DEPTH + 1);
  localparam int SAMPLE_W    = 24;
  localparam int STAMP_W     = 32;
  localparam int FRAC_BITS   = 8;
  localparam int AVG_W       = 40;
  localparam int CFG_W       = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int SUM_W       = SAMPLE_W + SLOT_W + 1;
  localparam int SPAN_W      = STAMP_W + 1;
  localparam int MAG_W       = AVG_W - FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(AVG_W + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTERED_MODE = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [STAMP_W-1:0]  stamp;
  } ring_entry_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic err;
  } div_req_t;

endpackage

[rtl/tsma_ring.sv]
module tsma_ring (
  input  logic                           clk,
  input  logic                           write,
  input  logic [tsma_pkg::SLOT_W-1:0]    waddr,
  input  tsma_pkg::ring_entry_t          wdata,
  input  logic [tsma_pkg::SLOT_W-1:0]    raddr,
  output tsma_pkg::ring_entry_t          rdata
);
  import tsma_pkg::*;

  ring_entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (write) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tsma_divider.sv]
module tsma_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  tsma_pkg::div_req_t                  req,
  input  logic [tsma_pkg::AVG_W-1:0]          dividend,
  input  logic [tsma_pkg::SPAN_W-1:0]         divisor,
  output logic                                done,
  output logic signed [tsma_pkg::AVG_W-1:0]   quotient,
  output logic                                err
);
  import tsma_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [SPAN_W-1:0]    rem;
  logic [AVG_W-1:0]     quo;
  logic [SPAN_W-1:0]    div_q;
  logic                 neg_q;

  logic [SPAN_W:0]      shifted;
  logic [SPAN_W+1:0]    diff;
  logic                 fits;
  logic [SPAN_W-1:0]    rem_next;
  logic [AVG_W-1:0]     quo_next;

  // One quotient bit per cycle: shift the dividend MSB into the remainder.
  always_comb begin
    shifted  = {rem, quo[AVG_W-1]};
    diff     = {1'b0, shifted} - {2'b00, div_q};
    fits     = !diff[SPAN_W+1];
    rem_next = fits ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];
    quo_next = {quo[AVG_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      err  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.err) begin
          done     <= 1'b1;
          err      <= 1'b1;
          quotient <= '0;
        end else begin
          busy  <= 1'b1;
          err   <= 1'b0;
          count <= DIV_CNT_W'(AVG_W);
          rem   <= '0;
          quo   <= dividend;
          div_q <= divisor;
          neg_q <= req.neg;
        end
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= quo_next;
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg_q ? -quo_next : quo_next;
        end
      end
    end
  end

endmodule

[rtl/time_span_moving_average.sv]
// An accepted sample passes S_ADJ/S_ADJ_W once per running-sum trim or extension (one in
// steady state, up to 256 after a window change); the input stalls until the FSM returns to
// S_IDLE, the stall set by the 40-step radix-2 divider. A span error skips the divide steps, a
// sample with no average skips the stamp reads and the divider; a waiting result holds the
// next average in S_HOLD. Reset (rst, synchronous, active high) clears the series, the sum and
// result_valid; window_length and centered_mode reset to 1. Ring contents are not cleared.
`include "time_span_moving_average_macros.svh"

module time_span_moving_average (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [tsma_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [tsma_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic signed [tsma_pkg::SAMPLE_W-1:0]   sample,
  input  logic [tsma_pkg::STAMP_W-1:0]           stamp,
  input  logic                                   final_item,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [tsma_pkg::AVG_W-1:0]      average,
  output logic                                   span_error
);
  import tsma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADJ, S_ADJ_W, S_RD0, S_RD1, S_RD2, S_WRITE, S_DIV, S_HOLD
  } state_t;

  state_t state;

  logic [CFG_W-1:0]        window_length;
  logic                    centered_mode;
  logic [COUNT_W-1:0]      seen;
  logic [COUNT_W-1:0]      held;
  logic [SLOT_W-1:0]       slot;
  logic signed [SUM_W-1:0] sum;

  logic [SAMPLE_W-1:0]     sample_q;
  logic [STAMP_W-1:0]      stamp_q;
  logic                    last_q;
  logic                    produce_q;
  logic                    skip_q;
  logic [COUNT_W-1:0]      target_q;
  logic [STAMP_W-1:0]      stamp_hi;
  logic [STAMP_W-1:0]      stamp_lo;

  // Window decision for the incoming sample.
  logic [COUNT_W-1:0] w_clamp;
  logic [COUNT_W-1:0] k;
  logic [COUNT_W-1:0] seen_next;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] target;
  logic               even_ctr;
  logic               short_series;
  logic               produce;
  logic               skip;

  always_comb begin
    if (window_length == '0) begin
      w_clamp = COUNT_W'(1);
    end else if (COUNT_W'(window_length) > COUNT_W'(RING_DEPTH)) begin
      w_clamp = COUNT_W'(RING_DEPTH);
    end else begin
      w_clamp = COUNT_W'(window_length);
    end
    seen_next    = (seen == COUNT_W'(RING_DEPTH)) ? seen : seen + COUNT_W'(1);
    even_ctr     = centered_mode && !w_clamp[0];
    k            = even_ctr ? w_clamp - COUNT_W'(1) : w_clamp;
    short_series = final_item && (seen_next < w_clamp);
    produce      = short_series || ((seen_next >= k) && !(even_ctr && final_item));
    skip         = short_series && centered_mode && !seen_next[0];
    if (short_series) begin
      cnt = skip ? seen_next - COUNT_W'(1) : seen_next;
    end else begin
      cnt = k;
    end
    // Number of older samples the running sum must cover before the write.
    if (produce) begin
      target = skip ? cnt : cnt - COUNT_W'(1);
    end else begin
      target = held;
    end
  end

  // Ring access.
  ring_entry_t        wdata;
  ring_entry_t        rdata;
  logic [SLOT_W-1:0]  raddr;
  logic               ring_write;

  always_comb begin
    case (state)
      S_ADJ: begin
        if (held > target_q) begin
          raddr = slot - held[SLOT_W-1:0];
        end else begin
          raddr = slot - SLOT_W'(1) - held[SLOT_W-1:0];
        end
      end
      S_RD1:   raddr = slot - target_q[SLOT_W-1:0];
      default: raddr = slot - SLOT_W'(1);
    endcase
    ring_write   = (state == S_WRITE);
    wdata.sample = sample_q;
    wdata.stamp  = stamp_q;
  end

  tsma_ring u_ring (
    .clk   (clk),
    .write (ring_write),
    .waddr (slot),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Final sum, span and divider request at the write step.
  logic signed [SUM_W-1:0] rd_ext;
  logic signed [SUM_W-1:0] new_ext;
  logic signed [SUM_W-1:0] sum_fin;
  logic [SUM_W-1:0]        mag;
  logic [STAMP_W-1:0]      hi;
  logic [STAMP_W-1:0]      lo;
  logic [SPAN_W-1:0]       diff;
  logic [SPAN_W-1:0]       divisor;
  logic [AVG_W-1:0]        dividend;
  div_req_t                div_req;

  always_comb begin
    rd_ext   = {{(SUM_W-SAMPLE_W){rdata.sample[SAMPLE_W-1]}}, rdata.sample};
    new_ext  = {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
    sum_fin  = skip_q ? sum : sum + new_ext;
    mag      = sum_fin[SUM_W-1] ? -sum_fin : sum_fin;
    dividend = {mag[MAG_W-1:0], FRAC_BITS'(0)};
    hi       = skip_q ? stamp_hi : stamp_q;
    lo       = (target_q == '0) ? stamp_q : stamp_lo;
    diff     = {1'b0, hi} - {1'b0, lo};
    divisor  = diff + SPAN_W'(1);
    div_req.start = (state == S_WRITE) && produce_q;
    div_req.neg   = sum_fin[SUM_W-1];
    div_req.err   = diff[SPAN_W-1];
  end

  logic                    div_done;
  logic signed [AVG_W-1:0] div_quotient;
  logic                    div_err;

  tsma_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quotient),
    .err      (div_err)
  );

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= CFG_W'(1);
      centered_mode <= 1'b1;
      seen          <= '0;
      held          <= '0;
      slot          <= '0;
      sum           <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: window_length <= cfg_data;
          CFG_CENTERED_MODE: centered_mode <= cfg_data[0];
          default: ;
        endcase
      end

      // Load a new result, or drop the old one once its transaction completes.
      if (state == S_HOLD && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            sample_q  <= sample;
            stamp_q   <= stamp;
            last_q    <= final_item;
            produce_q <= produce;
            skip_q    <= skip;
            target_q  <= target;
            seen      <= final_item ? '0 : seen_next;
            state     <= S_ADJ;
          end
        end
        S_ADJ: begin
          if (held != target_q) begin
            state <= S_ADJ_W;
          end else if (produce_q) begin
            state <= S_RD0;
          end else begin
            state <= S_WRITE;
          end
        end
        S_ADJ_W: begin
          // Trim the oldest sample or extend by one older sample.
          if (held > target_q) begin
            sum  <= sum - rd_ext;
            held <= held - COUNT_W'(1);
          end else begin
            sum  <= sum + rd_ext;
            held <= held + COUNT_W'(1);
          end
          state <= S_ADJ;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          stamp_hi <= rdata.stamp;
          state    <= S_RD2;
        end
        S_RD2: begin
          stamp_lo <= rdata.stamp;
          state    <= S_WRITE;
        end
        S_WRITE: begin
          if (last_q) begin
            slot <= '0;
            sum  <= '0;
            held <= '0;
          end else begin
            slot <= slot + SLOT_W'(1);
            sum  <= sum_fin;
            held <= held + COUNT_W'(!skip_q);
          end
          state <= produce_q ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!result_valid || !result_stall) begin
            average    <= div_quotient;
            span_error <= div_err;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TSMA_ASSERT_IMPLIES(a_held_within_series, state == S_IDLE, held <= seen, "running sum covers unseen samples")
  `TSMA_ASSERT_IMPLIES(a_error_zero_average, result_valid && span_error, average == '0, "span error with nonzero average")
  `TSMA_ASSERT_IMPLIES(a_done_only_in_div, div_done, state == S_DIV, "divider finished outside divide step")
  `TSMA_ASSERT_NEXT(a_end_clears_series, state == S_WRITE && last_q, seen == '0 && slot == '0 && held == '0, "series state not cleared")

endmodule
